// ===== src/text_terminal_screen_writer_macros.svh =====
// Assertion macros for the text terminal screen writer.
// Expects a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TEXT_TERMINAL_SCREEN_WRITER_MACROS_SVH
`define TEXT_TERMINAL_SCREEN_WRITER_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define TTS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/tts_pkg.sv =====
// Shared constants and types for the text terminal screen writer.
// No dependencies; used by the channel interfaces, the screen RAM and the top level.
package tts_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Word field widths
  localparam int CMD_W  = 1;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } state_t;

endpackage

// ===== src/tts_in_if.sv =====
// Input channel of the text terminal screen writer: valid/ready plus one command word.
// Depends on tts_pkg for field widths.
interface tts_in_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::CMD_W-1:0]  command;
  logic [tts_pkg::CHAR_W-1:0] char_in;
  logic [tts_pkg::ROW_W-1:0]  read_row;
  logic [tts_pkg::COL_W-1:0]  read_col;

  modport source (output valid, command, char_in, read_row, read_col, input ready);
  modport sink   (input valid, command, char_in, read_row, read_col, output ready);
endinterface

// ===== src/tts_out_if.sv =====
// Result channel of the text terminal screen writer: valid/ready plus one result word.
// Depends on tts_pkg for field widths.
interface tts_out_if;
  logic                       valid;
  logic                       ready;
  logic [tts_pkg::CHAR_W-1:0] cell_char;
  logic [tts_pkg::ROW_W-1:0]  cursor_row_out;
  logic [tts_pkg::COL_W-1:0]  cursor_col_out;
  logic                       scrolled;

  modport source (output valid, cell_char, cursor_row_out, cursor_col_out, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cursor_row_out, cursor_col_out, scrolled,
                  output ready);
endinterface

// ===== src/tts_ram.sv =====
// Screen cell RAM: one write port, one read port with registered read data.
// Depends on tts_pkg for default sizes.
module tts_ram #(
  parameter int DEPTH = tts_pkg::COLS_DEF * tts_pkg::ROWS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = tts_pkg::CHAR_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/text_terminal_screen_writer.sv =====
// Text terminal screen writer: top level. Needs tts_pkg, tts_in_if, tts_out_if, tts_ram
// and the assertion macros in text_terminal_screen_writer_macros.svh.
//
// A ROWS x COLS character screen with a cursor, held in one single-port-write RAM.
// Each input word is either a put (carriage return, line feed or a byte to store at
// the cursor) or a read of one cell for display refresh; every word gives exactly one
// result word with the cell (zero for puts), the cursor after the word and a scroll
// flag. Words are taken one at a time. A read or a put that does not scroll passes
// from acceptance through the done state into the output register; a put that scrolls
// first passes through the scroll state, which fills the new bottom row with spaces
// through the RAM's single write port. Scrolling itself only moves a top-of-screen row
// pointer, so rows form a circular buffer and nothing is copied. After reset the block
// clears the whole RAM to spaces, one cell a cycle, and accepts no word until that
// clear is done. A finished result waits in the output register without holding up
// acceptance of the next word.
`include "text_terminal_screen_writer_macros.svh"

module text_terminal_screen_writer #(
  parameter int COLS = tts_pkg::COLS_DEF,
  parameter int ROWS = tts_pkg::ROWS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tts_in_if.sink    in_ch,
  tts_out_if.source out_ch
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int RW1   = RW + 1;

  localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0]  COLS_A    = AW'(COLS);
  localparam logic [AW-1:0]  COLS_M1_A = AW'(COLS - 1);
  localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]  COL_LAST  = CW'(COLS - 1);
  localparam logic [RW1-1:0] ROWS_W    = RW1'(ROWS);

  // Logical row to physical row in the circular row buffer
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW1-1:0] s;
    s = {1'b0, top} + {1'b0, row};
    if (s >= ROWS_W) begin
      s = s - ROWS_W;
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * COLS_A + AW'(col);
  endfunction

  tts_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] top_r,  top_nxt;
  logic [RW-1:0] crow_r, crow_nxt;
  logic [CW-1:0] ccol_r, ccol_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] clr_last_r, clr_last_nxt;
  logic          pend_scr_r, pend_scr_nxt;
  logic          pend_rd_r,  pend_rd_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [tts_pkg::CHAR_W-1:0] out_cell_r,  out_cell_nxt;
  logic [tts_pkg::ROW_W-1:0]  out_row_r,   out_row_nxt;
  logic [tts_pkg::COL_W-1:0]  out_col_r,   out_col_nxt;
  logic                       out_scr_r,   out_scr_nxt;

  logic                       in_acc;
  logic                       is_put;
  logic                       is_read;
  logic                       rd_ok;
  logic                       out_free;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              cur_addr;
  logic [tts_pkg::CHAR_W-1:0] rd_data;

  // put decode
  logic          wr_chr;
  logic          down;
  logic          wrap;
  logic [RW-1:0] row_after;
  logic [CW-1:0] col_after;

  // RAM write port
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tts_pkg::CHAR_W-1:0] wdata;

  assign in_ch.ready = (state_r == tts_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_put      = (in_ch.command == tts_pkg::CMD_PUT);
  assign is_read     = (in_ch.command == tts_pkg::CMD_READ);
  assign out_free    = !out_valid_r || out_ch.ready;

  // Cells off the screen read as zero; their RAM read is skipped
  assign rd_ok   = (32'(in_ch.read_row) < 32'(ROWS)) && (32'(in_ch.read_col) < 32'(COLS));
  assign rd_addr = cell_addr(phys_row(top_r, RW'(in_ch.read_row)), CW'(in_ch.read_col));
  assign cur_addr = cell_addr(phys_row(top_r, crow_r), ccol_r);

  tts_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (tts_pkg::CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_acc && is_read && rd_ok),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Cursor movement for a put word. Line feed keeps the column.
  always_comb begin
    wr_chr    = 1'b0;
    down      = 1'b0;
    col_after = ccol_r;
    row_after = crow_r;
    if (is_put) begin
      priority if (in_ch.char_in == tts_pkg::CH_CR) begin
        col_after = '0;
      end else if (in_ch.char_in == tts_pkg::CH_LF) begin
        down = 1'b1;
      end else begin
        wr_chr = 1'b1;
        if (ccol_r == COL_LAST) begin
          col_after = '0;
          down      = 1'b1;
        end else begin
          col_after = ccol_r + 1'b1;
        end
      end
    end
    // moving off the bottom row scrolls and leaves the cursor on the last row
    wrap = down && (crow_r == ROW_LAST);
    if (down && !wrap) begin
      row_after = crow_r + 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tts_pkg::ST_WIPE: begin
        if (clr_addr_r == clr_last_r) state_nxt = tts_pkg::ST_IDLE;
      end
      tts_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = wrap ? tts_pkg::ST_SCROLL : tts_pkg::ST_DONE;
      end
      tts_pkg::ST_SCROLL: begin
        if (clr_addr_r == clr_last_r) state_nxt = tts_pkg::ST_DONE;
      end
      tts_pkg::ST_DONE: begin
        if (out_free) state_nxt = tts_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and RAM port control
  always_comb begin
    top_nxt       = top_r;
    crow_nxt      = crow_r;
    ccol_nxt      = ccol_r;
    clr_addr_nxt  = clr_addr_r;
    clr_last_nxt  = clr_last_r;
    pend_scr_nxt  = pend_scr_r;
    pend_rd_nxt   = pend_rd_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    we            = 1'b0;
    waddr         = cur_addr;
    wdata         = in_ch.char_in;

    unique case (state_r)
      tts_pkg::ST_WIPE, tts_pkg::ST_SCROLL: begin
        // space fill, one cell a cycle
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = tts_pkg::CH_SPACE;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      tts_pkg::ST_IDLE: begin
        if (in_acc) begin
          we           = wr_chr;
          crow_nxt     = row_after;
          ccol_nxt     = col_after;
          pend_scr_nxt = wrap;
          pend_rd_nxt  = is_read && rd_ok;
          if (wrap) begin
            // old top row becomes the new bottom row
            top_nxt      = (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
            clr_addr_nxt = cell_addr(top_r, '0);
            clr_last_nxt = cell_addr(top_r, '0) + COLS_M1_A;
          end
        end
      end
      tts_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = pend_rd_r ? rd_data : '0;
          out_row_nxt   = tts_pkg::ROW_W'(crow_r);
          out_col_nxt   = tts_pkg::COL_W'(ccol_r);
          out_scr_nxt   = pend_scr_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tts_pkg::ST_WIPE;
      top_r       <= '0;
      crow_r      <= '0;
      ccol_r      <= '0;
      clr_addr_r  <= '0;
      clr_last_r  <= LAST_ADDR;
      pend_scr_r  <= 1'b0;
      pend_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_last_r  <= clr_last_nxt;
      pend_scr_r  <= pend_scr_nxt;
      pend_rd_r   <= pend_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_char      = out_cell_r;
  assign out_ch.cursor_row_out = out_row_r;
  assign out_ch.cursor_col_out = out_col_r;
  assign out_ch.scrolled       = out_scr_r;

  // Assertions
  `TTS_ASSERT_IMP(a_scroll_pending, state_r == tts_pkg::ST_SCROLL, pend_scr_r, "row clear without a scroll")
  `TTS_ASSERT_ALWAYS(a_cursor_row, crow_r <= ROW_LAST, "cursor row off the screen")
  `TTS_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r) == tts_pkg::ST_DONE, "result word not from done state")
  `TTS_ASSERT_IMP(a_clear_range, (state_r == tts_pkg::ST_WIPE) || (state_r == tts_pkg::ST_SCROLL), clr_addr_r <= clr_last_r, "space fill ran past its end")

endmodule

// ===== tb/sv/text_terminal_screen_writer_tb.sv =====
// Self-checking testbench for the text terminal screen writer at the default screen size.
// Depends on tts_pkg, tts_in_if, tts_out_if and the text_terminal_screen_writer top level.
// A shadow screen predicts every result word; directed table first, then random traffic.
module text_terminal_screen_writer_tb;
  import tts_pkg::*;

  localparam int COLS = COLS_DEF;
  localparam int ROWS = ROWS_DEF;

  // Words per random phase; with the directed table this comes to about 450 words.
  localparam int PHASE_WORDS = 107;
  // A scrolling put also space-fills a row of COLS cells, so the wait
  // at the end is sized from COLS before calling it done.
  localparam int TAIL_CYCLES = 2 * COLS + 16;

  // One input word and one result word, in port order.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_in;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } term_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic              scrolled;
  } screen_res_t;

  // Directed row: the word, and a typed-in result where it is obvious.
  typedef struct {
    term_word_t  word;
    bit          typed;
    screen_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tts_in_if  in_ch();
  tts_out_if out_ch();

  text_terminal_screen_writer #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the screen and cursor, updated as each word is accepted.
  logic [CHAR_W-1:0] shadow [ROWS][COLS];
  int                cur_row;
  int                cur_col;

  screen_res_t expected_words [$];
  int          n_fail;
  int          n_sent;

  // Idling knobs, in percent of cycles.
  int gap_pct;
  int stall_pct;

  dir_row_t dir_tab [22];

  // Cursor one row down; past the bottom the rows shift up and a blank
  // row comes in at the bottom. Returns 1 when the screen scrolled.
  function automatic logic cursor_down();
    cur_row++;
    if (cur_row < ROWS) begin
      return 1'b0;
    end
    cur_row = ROWS - 1;
    for (int r = 0; r < ROWS - 1; r++) begin
      shadow[r] = shadow[r + 1];
    end
    for (int c = 0; c < COLS; c++) begin
      shadow[ROWS - 1][c] = CH_SPACE;
    end
    return 1'b1;
  endfunction

  // Applies one word to the shadow and gives the result word it should cause.
  function automatic screen_res_t next_screen_result(term_word_t w);
    screen_res_t r;
    r = '0;
    if (w.command == CMD_READ) begin
      // Cells off the screen read back as zero; nothing changes.
      if (w.read_row < ROWS && w.read_col < COLS) begin
        r.cell_char = shadow[w.read_row][w.read_col];
      end
    end else if (w.char_in == CH_CR) begin
      cur_col = 0;
    end else if (w.char_in == CH_LF) begin
      // Line feed moves the row only; the column stays put.
      r.scrolled = cursor_down();
    end else begin
      shadow[cur_row][cur_col] = w.char_in;
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col    = 0;
        r.scrolled = cursor_down();
      end
    end
    // Cursor is reported at the field widths only.
    r.cursor_row_out = ROW_W'(cur_row);
    r.cursor_col_out = COL_W'(cur_col);
    return r;
  endfunction

  // Put word: the read address is don't-care, so fill it with noise.
  function automatic term_word_t put_word(logic [CHAR_W-1:0] ch);
    term_word_t w;
    w.command  = CMD_PUT;
    w.char_in  = ch;
    w.read_row = ROW_W'($urandom);
    w.read_col = COL_W'($urandom);
    return w;
  endfunction

  // Read word: char_in is don't-care.
  function automatic term_word_t read_word(int row, int col);
    term_word_t w;
    w.command  = CMD_READ;
    w.char_in  = CHAR_W'($urandom);
    w.read_row = ROW_W'(row);
    w.read_col = COL_W'(col);
    return w;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Drives one word. Entered and left at a falling edge, so valid only
  // drops when a gap is actually taken and never bounces within a step.
  task automatic send_word(input term_word_t w, input bit typed, input screen_res_t typed_res);
    screen_res_t pred;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= w.command;
    in_ch.char_in  <= w.char_in;
    in_ch.read_row <= w.read_row;
    in_ch.read_col <= w.read_col;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    // Accepted at this edge: the shadow always moves on, even where the
    // expected word comes from the table.
    pred = next_screen_result(w);
    expected_words.push_back(typed ? typed_res : pred);
    n_sent++;
    @(negedge clk);
  endtask

  // Result side: ready changes on the falling edge as the stall knob says.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    screen_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: cell %0d row %0d col %0d scrolled %0d",
               out_ch.cell_char, out_ch.cursor_row_out, out_ch.cursor_col_out,
               out_ch.scrolled);
        n_fail++;
      end else begin
        want = expected_words.pop_front();
        check_field("cell_char", 32'(want.cell_char), 32'(out_ch.cell_char));
        check_field("cursor_row_out", 32'(want.cursor_row_out), 32'(out_ch.cursor_row_out));
        check_field("cursor_col_out", 32'(want.cursor_col_out), 32'(out_ch.cursor_col_out));
        check_field("scrolled", 32'(want.scrolled), 32'(out_ch.scrolled));
      end
    end
  end

  // Watchdog: the block clears its whole RAM after reset and each scroll
  // space-fills a row, so this is several times the slowest run.
  initial begin
    #6_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int kind;
    int len;
    int ph;

    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_PUT;
    in_ch.char_in  = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    rst_n          = 1'b0;
    gap_pct        = 0;
    stall_pct      = 0;
    n_fail         = 0;
    n_sent         = 0;

    // Shadow after reset: blank screen, cursor home.
    foreach (shadow[r, c]) begin
      shadow[r][c] = CH_SPACE;
    end
    cur_row = 0;
    cur_col = 0;

    // Directed words. Reads carry junk in char_in and puts junk in the
    // address to show both are ignored.
    dir_tab = '{
      // blank screen corners, then off-screen reads giving zero
      '{'{CMD_READ, 8'hA5, 5'd0,  7'd0},   1'b1, '{CH_SPACE, 5'd0, 7'd0, 1'b0}},
      '{'{CMD_READ, 8'hFF, 5'd24, 7'd79},  1'b1, '{CH_SPACE, 5'd0, 7'd0, 1'b0}},
      '{'{CMD_READ, 8'h00, 5'd25, 7'd0},   1'b1, '{8'h00,    5'd0, 7'd0, 1'b0}},
      '{'{CMD_READ, 8'h5A, 5'd0,  7'd80},  1'b1, '{8'h00,    5'd0, 7'd0, 1'b0}},
      '{'{CMD_READ, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00,    5'd0, 7'd0, 1'b0}},
      // plain bytes, both extremes of char_in
      '{'{CMD_PUT,  8'h41, 5'd31, 7'd127}, 1'b1, '{8'h00,    5'd0, 7'd1, 1'b0}},
      '{'{CMD_READ, 8'h00, 5'd0,  7'd0},   1'b1, '{8'h41,    5'd0, 7'd1, 1'b0}},
      '{'{CMD_PUT,  8'hFF, 5'd0,  7'd0},   1'b1, '{8'h00,    5'd0, 7'd2, 1'b0}},
      '{'{CMD_PUT,  8'h00, 5'd24, 7'd79},  1'b1, '{8'h00,    5'd0, 7'd3, 1'b0}},
      '{'{CMD_READ, 8'h00, 5'd0,  7'd1},   1'b1, '{8'hFF,    5'd0, 7'd3, 1'b0}},
      '{'{CMD_READ, 8'hFF, 5'd0,  7'd2},   1'b1, '{8'h00,    5'd0, 7'd3, 1'b0}},
      // carriage return and line feed
      '{'{CMD_PUT,  CH_CR, 5'd0,  7'd0},   1'b1, '{8'h00,    5'd0, 7'd0, 1'b0}},
      '{'{CMD_PUT,  CH_LF, 5'd0,  7'd0},   1'b1, '{8'h00,    5'd1, 7'd0, 1'b0}},
      '{'{CMD_PUT,  8'h42, 5'd3,  7'd3},   1'b0, '0},
      // line feed keeps the column
      '{'{CMD_PUT,  CH_LF, 5'd0,  7'd0},   1'b1, '{8'h00,    5'd2, 7'd1, 1'b0}},
      '{'{CMD_PUT,  CH_CR, 5'd0,  7'd0},   1'b0, '0},
      '{'{CMD_READ, 8'h00, 5'd1,  7'd0},   1'b0, '0},
      // neighbours of the control codes are stored like any byte
      '{'{CMD_PUT,  8'h0C, 5'd0,  7'd0},   1'b0, '0},
      '{'{CMD_PUT,  8'h0B, 5'd0,  7'd0},   1'b0, '0},
      '{'{CMD_PUT,  8'h09, 5'd0,  7'd0},   1'b0, '0},
      '{'{CMD_PUT,  CH_SPACE, 5'd0, 7'd0}, 1'b0, '0},
      '{'{CMD_READ, 8'h00, 5'd2,  7'd0},   1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The block clears its RAM first; send_word just waits for ready.
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random part in four idling phases: none, sender gaps, receiver
    // stalls, both. Traffic is built from terminal-like runs so the cursor
    // gets to the bottom row and scrolls often.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 36; stall_pct = 36; end
      endcase
      while (n_sent < $size(dir_tab) + (ph + 1) * PHASE_WORDS) begin
        kind = $urandom_range(9);
        if (kind <= 3) begin
          // Text line ended by CR LF; now and then long enough to wrap.
          len = ($urandom_range(3) == 0) ? $urandom_range(COLS + 10, COLS - 5)
                                         : $urandom_range(20, 1);
          repeat (len) begin
            if ($urandom_range(7) == 0) begin
              send_word(put_word(CHAR_W'($urandom_range(255))), 1'b0, '0);
            end else begin
              send_word(put_word(CHAR_W'($urandom_range(8'h7E, 8'h21))), 1'b0, '0);
            end
          end
          send_word(put_word(CH_CR), 1'b0, '0);
          send_word(put_word(CH_LF), 1'b0, '0);
        end else if (kind <= 6) begin
          // Display refresh reads: the cursor row, anywhere, or off screen.
          repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(7))
              0: send_word(read_word($urandom_range(31), $urandom_range(127)), 1'b0, '0);
              1, 2, 3: send_word(read_word(cur_row, $urandom_range(COLS - 1)), 1'b0, '0);
              default: send_word(read_word($urandom_range(ROWS - 1),
                                           $urandom_range(COLS - 1)), 1'b0, '0);
            endcase
          end
        end else if (kind == 7) begin
          // Run of line feeds, long enough at times to go past the bottom row.
          repeat ($urandom_range(30, 1)) begin
            send_word(put_word(CH_LF), 1'b0, '0);
          end
        end else begin
          // Noise: any command, any byte, any address.
          repeat ($urandom_range(8, 1)) begin
            send_word($urandom_range(1) ? read_word($urandom_range(31), $urandom_range(127))
                                        : put_word(CHAR_W'($urandom_range(255))),
                      1'b0, '0);
          end
        end
      end
    end

    in_ch.valid <= 1'b0;

    // Drain, then give stray words time to show up.
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_fail == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
